### sv/mvsc_pkg.sv
package mvsc_pkg;

  // Field widths
  localparam int unsigned MOIST_W  = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned HYST_W   = 8;
  localparam int unsigned DISC_W   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STEPS_W  = 10;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR  = 3'd0,
    CFG_HIGH_THR = 3'd1,
    CFG_HYST     = 3'd2,
    CFG_DISC_THR = 3'd3,
    CFG_PERIOD   = 3'd4,
    CFG_STEPS    = 3'd5
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0]    LOW_THR_RST  = 10'd440;
  localparam logic [THR_W-1:0]    HIGH_THR_RST = 10'd690;
  localparam logic [HYST_W-1:0]   HYST_RST     = 8'd40;
  localparam logic [DISC_W-1:0]   DISC_THR_RST = 8'd8;
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd1000;
  localparam logic [STEPS_W-1:0]  STEPS_RST    = 10'd256;

  // Moisture levels
  typedef enum logic [1:0] {
    LVL_DISC = 2'd0,
    LVL_DRY  = 2'd1,
    LVL_OKAY = 2'd2,
    LVL_WET  = 2'd3
  } level_t;

  // Stepper phases
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_LAST = 2'd3;

endpackage

### sv/moisture_valve_stepper_controller.sv
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+-----------------------------------------
// in_     | input     | in_valid/in_stall  | in_moisture, in_now_ms
// out_    | output    | out_valid/out_stall| out_coils, out_level, out_level_updated,
//         |           |                    | out_water_on, out_valve_position
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One item per clock sustained while out_stall stays low. An accepted item is held
// in the input register, then the classifier and stepper logic evaluate it against
// the loop state and the result lands in the output register.
// Synchronous active-low reset returns config to defaults and clears all loop state.
// A stalled output holds its item; the input register then holds too, and in_stall
// rises only when both the input register and the output register are occupied.
module moisture_valve_stepper_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mvsc_pkg::MOIST_W-1:0]         in_moisture,
  input  logic [mvsc_pkg::TIME_W-1:0]          in_now_ms,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mvsc_pkg::COIL_W-1:0]          out_coils,
  output mvsc_pkg::level_t                     out_level,
  output logic                                 out_level_updated,
  output logic                                 out_water_on,
  output logic [mvsc_pkg::POS_W-1:0]           out_valve_position,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mvsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mvsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import mvsc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]    low_thr_r;
  logic [THR_W-1:0]    high_thr_r;
  logic [HYST_W-1:0]   hyst_r;
  logic [DISC_W-1:0]   disc_thr_r;
  logic [PERIOD_W-1:0] period_r;
  logic [STEPS_W-1:0]  steps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= LOW_THR_RST;
      high_thr_r <= HIGH_THR_RST;
      hyst_r     <= HYST_RST;
      disc_thr_r <= DISC_THR_RST;
      period_r   <= PERIOD_RST;
      steps_r    <= STEPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOW_THR:  low_thr_r  <= cfg_data[THR_W-1:0];
        CFG_HIGH_THR: high_thr_r <= cfg_data[THR_W-1:0];
        CFG_HYST:     hyst_r     <= cfg_data[HYST_W-1:0];
        CFG_DISC_THR: disc_thr_r <= cfg_data[DISC_W-1:0];
        CFG_PERIOD:   period_r   <= cfg_data[PERIOD_W-1:0];
        CFG_STEPS:    steps_r    <= cfg_data[STEPS_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeding output register
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic [MOIST_W-1:0]   s1_moist_r;
  logic [TIME_W-1:0]    s1_now_r;
  logic                 out_valid_r;
  logic                 out_free;   // output register can take a new item
  logic                 advance;    // input register item moves into output register
  logic                 in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take || advance) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_moist_r <= in_moisture;
      s1_now_r   <= in_now_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Loop state
  // ---------------------------------------------------------------------------
  level_t              prev_level_r, prev_level_nxt;
  logic [TIME_W-1:0]   last_ms_r, last_ms_nxt;
  logic                never_upd_r;
  logic                watering_r, watering_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [COIL_W-1:0]   coil_r, coil_nxt;
  logic                updated;

  // Classifier: the first tick always evaluates, later ones once the elapsed
  // time (mod 2^32) strictly exceeds the period.
  logic [TIME_W-1:0]   elapsed;
  logic [DISC_W:0]     disc_lim;
  logic [THR_W:0]      hi_lim;
  logic [THR_W:0]      lo_lim;
  level_t              lvl;

  assign elapsed = s1_now_r - last_ms_r;
  assign updated = never_upd_r || (elapsed > {{(TIME_W-PERIOD_W){1'b0}}, period_r});

  // Hysteresis: disconnect limit doubles while disconnected; wet limit lifts
  // unless already wet; dry limit lifts while disconnected or dry.
  always_comb begin
    disc_lim = {1'b0, disc_thr_r} +
               ((prev_level_r == LVL_DISC) ? {1'b0, disc_thr_r} : '0);
    hi_lim   = {1'b0, high_thr_r} +
               ((prev_level_r != LVL_WET) ? {{(THR_W+1-HYST_W){1'b0}}, hyst_r} : '0);
    lo_lim   = {1'b0, low_thr_r} +
               ((prev_level_r == LVL_DISC || prev_level_r == LVL_DRY) ?
                {{(THR_W+1-HYST_W){1'b0}}, hyst_r} : '0);
    if ({1'b0, s1_moist_r} < {{(MOIST_W-DISC_W){1'b0}}, disc_lim}) begin
      lvl = LVL_DISC;
    end else if ({1'b0, s1_moist_r} > hi_lim) begin
      lvl = LVL_WET;
    end else if ({1'b0, s1_moist_r} < lo_lim) begin
      lvl = LVL_DRY;
    end else begin
      lvl = LVL_OKAY;
    end
  end

  always_comb begin
    prev_level_nxt = prev_level_r;
    last_ms_nxt    = last_ms_r;
    watering_nxt   = watering_r;
    if (updated) begin
      prev_level_nxt = lvl;
      last_ms_nxt    = s1_now_r;
      watering_nxt   = lvl inside {LVL_DRY, LVL_OKAY};
    end
  end

  // Wave-drive stepper: one coil phase per tick; a full rotation of four
  // phases counts one position step. Target is valve_steps while watering,
  // zero otherwise; the position wraps at twice valve_steps.
  logic [POS_W-1:0]    pos_inc;
  logic [POS_W-1:0]    wrap_pt;
  logic                want_move;

  assign pos_inc = pos_r + 1'b1;
  assign wrap_pt = {steps_r, 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    coil_nxt  = coil_r;
    want_move = watering_nxt ? (pos_r != {1'b0, steps_r}) : (pos_r != '0);
    if (phase_r != PHASE_IDLE) begin
      coil_nxt = (coil_r & ~(COIL_W'(1) << (phase_r - 2'd1))) | (COIL_W'(1) << phase_r);
      if (phase_r == PHASE_LAST) begin
        phase_nxt = PHASE_IDLE;
        pos_nxt   = (pos_inc == wrap_pt) ? '0 : pos_inc;
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
    end else if (want_move) begin
      phase_nxt = 2'd1;
      coil_nxt  = (coil_r & 4'b0111) | 4'b0001;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= LVL_DISC;
      last_ms_r    <= '0;
      never_upd_r  <= 1'b1;
      watering_r   <= 1'b0;
      phase_r      <= PHASE_IDLE;
      pos_r        <= '0;
      coil_r       <= '0;
    end else if (advance) begin
      prev_level_r <= prev_level_nxt;
      last_ms_r    <= last_ms_nxt;
      never_upd_r  <= 1'b0;
      watering_r   <= watering_nxt;
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      coil_r       <= coil_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [COIL_W-1:0]  out_coils_r;
  level_t             out_level_r;
  logic               out_upd_r;
  logic               out_water_r;
  logic [POS_W-1:0]   out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_coils_r <= coil_nxt;
      out_level_r <= prev_level_nxt;
      out_upd_r   <= updated;
      out_water_r <= watering_nxt;
      out_pos_r   <= pos_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_coils          = out_coils_r;
  assign out_level          = out_level_r;
  assign out_level_updated  = out_upd_r;
  assign out_water_on       = out_water_r;
  assign out_valve_position = out_pos_r;

endmodule

### tb/moisture_valve_stepper_controller_tb.sv
`timescale 1ns / 1ps

module moisture_valve_stepper_controller_tb;
  import mvsc_pkg::*;

  // Hard stop on the number of clock cycles.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One result item as the block reports it.
  typedef struct packed {
    logic [COIL_W-1:0] coils;
    level_t            level;
    logic              updated;
    logic              water_on;
    logic [POS_W-1:0]  position;
  } valve_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [MOIST_W-1:0]    in_moisture;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic [COIL_W-1:0]     out_coils;
  level_t                out_level;
  logic                  out_level_updated;
  logic                  out_water_on;
  logic [POS_W-1:0]      out_valve_position;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  moisture_valve_stepper_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_moisture        (in_moisture),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_coils          (out_coils),
    .out_level          (out_level),
    .out_level_updated  (out_level_updated),
    .out_water_on       (out_water_on),
    .out_valve_position (out_valve_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Register shadow, starts at the reset values.
  logic [THR_W-1:0]    low_thr_q  = LOW_THR_RST;
  logic [THR_W-1:0]    high_thr_q = HIGH_THR_RST;
  logic [HYST_W-1:0]   hyst_q     = HYST_RST;
  logic [DISC_W-1:0]   disc_thr_q = DISC_THR_RST;
  logic [PERIOD_W-1:0] period_q   = PERIOD_RST;
  logic [STEPS_W-1:0]  steps_q    = STEPS_RST;

  // Control-loop state of the predictor.
  level_t              last_level  = LVL_DISC;
  logic [TIME_W-1:0]   class_stamp = '0;
  bit                  first_tick  = 1'b1;
  bit                  water_req   = 1'b0;
  int unsigned         coil_phase  = 0;
  logic [POS_W-1:0]    valve_pos   = '0;
  logic [COIL_W-1:0]   coil_drive  = '0;

  valve_result_t       pending_results[$];
  int unsigned         errors      = 0;
  int unsigned         cycle_count = 0;

  // Traffic shaping: random idling on/off, a receiver hold-off request in
  // cycles, and a run of sender ticks with no gaps.
  bit                  idle_on     = 1'b1;
  int unsigned         hold_req    = 0;
  int unsigned         send_calm   = 0;
  logic [TIME_W-1:0]   clock_ms    = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void report_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      report_error($sformatf("%s: expected %0d, got %0d", name, want, got));
  endfunction

  // One control tick: classify when due, then one stepper move.
  function automatic valve_result_t predict_tick(logic [MOIST_W-1:0] m,
                                                 logic [TIME_W-1:0] now);
    valve_result_t     res;
    logic [TIME_W-1:0] elapsed;
    int unsigned       disc_lim;
    int unsigned       wet_lim;
    int unsigned       dry_lim;
    bit                due;
    elapsed = now - class_stamp;
    due = first_tick || (elapsed > period_q);
    if (due) begin
      class_stamp = now;
      first_tick  = 1'b0;
      // hysteresis: lift depends on the level we are coming from
      disc_lim = disc_thr_q + ((last_level == LVL_DISC) ? disc_thr_q : 8'd0);
      wet_lim  = high_thr_q + ((last_level != LVL_WET) ? hyst_q : 8'd0);
      dry_lim  = low_thr_q + ((last_level == LVL_DISC || last_level == LVL_DRY) ?
                              hyst_q : 8'd0);
      if (m < disc_lim)     last_level = LVL_DISC;
      else if (m > wet_lim) last_level = LVL_WET;
      else if (m < dry_lim) last_level = LVL_DRY;
      else                  last_level = LVL_OKAY;
      water_req = (last_level == LVL_DRY || last_level == LVL_OKAY);
    end

    // wave drive: one coil per tick, four ticks per full step
    if (coil_phase != 0) begin
      coil_drive[coil_phase - 1] = 1'b0;
      coil_drive[coil_phase]     = 1'b1;
      coil_phase++;
      if (coil_phase == 4) begin
        coil_phase = 0;
        valve_pos  = valve_pos + 1'b1;
        if (valve_pos == {steps_q, 1'b0}) valve_pos = '0;
      end
    end else if (water_req ? (valve_pos != steps_q) : (valve_pos != '0)) begin
      coil_phase    = 1;
      coil_drive[3] = 1'b0;
      coil_drive[0] = 1'b1;
    end

    res.coils    = coil_drive;
    res.level    = last_level;
    res.updated  = due;
    res.water_on = water_req;
    res.position = valve_pos;
    return res;
  endfunction

  // Scoreboard: check results, track register writes, predict accepted items.
  always @(posedge clk) begin
    valve_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_error("result item with nothing pending");
        end else begin
          want = pending_results.pop_front();
          check_field("coils", want.coils, out_coils);
          check_field("level", want.level, out_level);
          check_field("level_updated", want.updated, out_level_updated);
          check_field("water_on", want.water_on, out_water_on);
          check_field("valve_position", want.position, out_valve_position);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOW_THR:  low_thr_q  = cfg_data[THR_W-1:0];
          CFG_HIGH_THR: high_thr_q = cfg_data[THR_W-1:0];
          CFG_HYST:     hyst_q     = cfg_data[HYST_W-1:0];
          CFG_DISC_THR: disc_thr_q = cfg_data[DISC_W-1:0];
          CFG_PERIOD:   period_q   = cfg_data[PERIOD_W-1:0];
          CFG_STEPS:    steps_q    = cfg_data[STEPS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_results.push_back(predict_tick(in_moisture, in_now_ms));
    end
  end

  // Receiver: random stall bursts, quiet stretches, and requested hold-offs.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned r;
    stall_left = 0;
    calm_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req   = 0;
        calm_left  = 0;
      end else if (stall_left == 0 && calm_left == 0 && idle_on) begin
        r = $urandom_range(0, 15);
        if (r < 3)       stall_left = $urandom_range(1, 9);
        else if (r == 3) calm_left  = $urandom_range(10, 40);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (calm_left != 0) calm_left--;
      end
    end
  end

  // Offer one item, with an occasional idle gap ahead of it; returns on accept.
  // Valid stays high afterwards so back-to-back items run at full rate.
  task automatic send_tick(logic [MOIST_W-1:0] m, logic [TIME_W-1:0] stamp);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (idle_on) begin
      if (send_calm != 0) begin
        send_calm--;
      end else begin
        r = $urandom_range(0, 15);
        if (r < 3)       gap       = $urandom_range(1, 9);
        else if (r == 3) send_calm = $urandom_range(10, 40);
      end
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_moisture <= m;
    in_now_ms   <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every pending result has been checked.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Biased toward the range ends.
  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Random tick: timestamps mostly around the update period, moisture mostly
  // near one of the live thresholds so the hysteresis bands get exercised.
  task automatic send_random_tick();
    int unsigned r;
    int          m;
    r = $urandom_range(0, 9);
    if (r == 0)      clock_ms = $urandom;
    else if (r == 2) clock_ms = clock_ms + period_q + 1;
    else if (r != 1) clock_ms = clock_ms + $urandom_range(0, 2 * period_q + 2);
    r = $urandom_range(0, 9);
    if (r < 3) begin
      m = $urandom_range(0, 1023);
    end else if (r == 3) begin
      m = $urandom_range(0, 1) * 1023;
    end else begin
      case ($urandom_range(0, 5))
        0:       m = disc_thr_q;
        1:       m = 2 * disc_thr_q;
        2:       m = low_thr_q;
        3:       m = low_thr_q + hyst_q;
        4:       m = high_thr_q;
        default: m = high_thr_q + hyst_q;
      endcase
      m = m + int'($urandom_range(0, 4)) - 2;
      if (m < 0) m = 0;
      if (m > 1023) m = 1023;
    end
    send_tick(MOIST_W'(m), clock_ms);
  endtask

  // Reset settings: first tick, period boundary, every level and its
  // hysteresis edges, doubled disconnect limit, timestamp wrap.
  task automatic test_default_levels();
    send_tick(500, 0);            // first tick classifies even at stamp zero
    send_tick(1023, 500);
    send_tick(1023, 1000);        // exactly one period: not yet due
    send_tick(1023, 1001);
    send_tick(0, 2002);
    send_tick(15, 3003);          // disconnect limit doubled from disconnected
    send_tick(16, 4004);
    send_tick(479, 5005);         // dry band lifted by hysteresis
    send_tick(480, 6006);
    send_tick(440, 7007);         // from okay the dry limit drops back
    send_tick(439, 8008);
    send_tick(730, 9009);
    send_tick(731, 10010);
    send_tick(691, 11011);        // from wet the wet limit drops back
    send_tick(690, 12012);
    send_tick(7, 13013);
    send_tick(500, 32'hFFFF_FFF0);
    send_tick(500, 32'h0000_0010); // elapsed across the wrap is small
    send_tick(1023, 32'h0000_03F9);
    clock_ms = 32'h0000_03F9;
  endtask

  // Zero valve steps while watering: the position sits past the wrap point
  // and keeps counting up toward the 11-bit rollover.
  task automatic test_valve_wraparound();
    wait_drain();
    write_reg(CFG_LOW_THR, 100);
    write_reg(CFG_HIGH_THR, 900);
    write_reg(CFG_HYST, 0);
    write_reg(CFG_DISC_THR, 0);
    write_reg(CFG_PERIOD, 0);     // classify on every new stamp
    write_reg(CFG_STEPS, 0);
    repeat (32) begin
      clock_ms++;
      send_tick(500, clock_ms);
    end
  endtask

  task automatic test_register_extremes();
    wait_drain();
    write_reg(CFG_LOW_THR, 1023);
    write_reg(CFG_HIGH_THR, 1023);
    write_reg(CFG_HYST, 255);
    write_reg(CFG_DISC_THR, 255);
    write_reg(CFG_PERIOD, 65535);
    write_reg(CFG_STEPS, 1023);
    clock_ms += 65536;
    send_tick(0, clock_ms);
    clock_ms += 65536;
    send_tick(509, clock_ms);
    clock_ms += 65536;
    send_tick(510, clock_ms);
    clock_ms += 65535;            // one full period: not due
    send_tick(1023, clock_ms);
    clock_ms += 1;
    send_tick(1023, clock_ms);
    wait_drain();
    write_reg(CFG_LOW_THR, 0);
    write_reg(CFG_HIGH_THR, 0);
    write_reg(CFG_HYST, 0);
    write_reg(CFG_DISC_THR, 0);
    write_reg(CFG_PERIOD, 0);
    write_reg(CFG_STEPS, 0);
    clock_ms += 1;
    send_tick(0, clock_ms);
    send_tick(1, clock_ms);       // same stamp with zero period: not due
    clock_ms += 1;
    send_tick(1, clock_ms);
    clock_ms += 1;
    send_tick(0, clock_ms);
  endtask

  // Receiver holds off while the sender keeps pushing, so the block fills and
  // stalls its input; then the sender pauses until everything has drained.
  task automatic test_backpressure();
    idle_on = 1'b0;
    wait_drain();
    hold_req = 40;
    repeat (20) send_random_tick();
    wait_drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    repeat (8) begin
      wait_drain();
      write_reg(CFG_LOW_THR, pick_value(0, 1023));
      write_reg(CFG_HIGH_THR, pick_value(0, 1023));
      write_reg(CFG_HYST, pick_value(0, 255));
      write_reg(CFG_DISC_THR, ($urandom_range(0, 3) == 0) ? pick_value(0, 255) :
                              $urandom_range(0, 40));
      write_reg(CFG_PERIOD, ($urandom_range(0, 3) == 0) ? pick_value(0, 65535) :
                            $urandom_range(0, 30));
      write_reg(CFG_STEPS, ($urandom_range(0, 3) == 0) ? pick_value(0, 1023) :
                           $urandom_range(0, 6));
      repeat (40) send_random_tick();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_flow();
    idle_on = 1'b0;
    repeat (40) send_random_tick();
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_moisture = '0;
    in_now_ms   = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_LOW_THR;
    cfg_data    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_levels();
    test_valve_wraparound();
    test_register_extremes();
    test_backpressure();
    test_random_settings();
    test_steady_flow();

    wait_drain();
    // give stray results from the pipeline time to show up
    repeat (8) @(posedge clk);
    errors += pending_results.size();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
